[rtl/core/bfknn_pkg.sv]
// Shared constants, types and sequencer states for the brute-force k-NN search block.
package bfknn_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned MAX_DIMS   = 8;
  localparam int unsigned MAX_K      = 32;
  localparam int unsigned COORD_BITS = 16;

  localparam int unsigned PIDX_W  = $clog2(MAX_POINTS);
  localparam int unsigned DIM_W   = $clog2(MAX_DIMS);
  localparam int unsigned RANK_W  = $clog2(MAX_K);
  localparam int unsigned ADDR_W  = PIDX_W + DIM_W;
  localparam int unsigned DIFF_W  = COORD_BITS + 1;
  localparam int unsigned SQ_W    = 2 * COORD_BITS;
  localparam int unsigned DIST_W  = SQ_W + DIM_W;

  // Configuration register widths and indexes
  localparam int unsigned PCNT_W  = 11;
  localparam int unsigned DCNT_W  = 4;
  localparam int unsigned KCNT_W  = 6;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] CFG_POINT_COUNT     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_DIMENSION_COUNT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_NEIGHBOR_COUNT  = 2'd2;

  localparam logic [PCNT_W-1:0] PCNT_RESET = 11'd2;
  localparam logic [DCNT_W-1:0] DCNT_RESET = 4'd1;
  localparam logic [KCNT_W-1:0] KCNT_RESET = 6'd5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QLOAD,
    ST_DIST,
    ST_DRAIN,
    ST_SCAN,
    ST_SCAN_END,
    ST_EMIT
  } state_e;

  // Tag that travels down the distance pipeline with each coordinate read
  typedef struct packed {
    logic              v;
    logic              qload;
    logic [PIDX_W-1:0] j;
    logic [DIM_W-1:0]  d;
    logic              first;
    logic              last;
  } pipe_tag_t;

endpackage

[rtl/core/brute_force_knn_search.sv]
// Brute-force k-nearest-neighbor search over a stored point set, squared Euclidean metric.
// Load: one coordinate per transfer, busy stays low.
// Query: busy while it fetches the query point, streams every coordinate of the N points through
//   the shared subtract/square/accumulate unit, drains it and runs k selection passes over the points.
// One result per pass; no stall.
// Reset: point_count 2, dimension_count 1, neighbor_count 5; stores not cleared, busy low.
module brute_force_knn_search
  import bfknn_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [CIDX_W-1:0]     cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,

  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  operation_i,
  input  logic [PIDX_W-1:0]     point_index_i,
  input  logic [DIM_W-1:0]      dim_index_i,
  input  logic signed [COORD_BITS-1:0] coord_value_i,

  output logic                  result_valid_o,
  output logic [PIDX_W-1:0]     query_index_o,
  output logic [PIDX_W-1:0]     neighbor_index_o,
  output logic [DIST_W-1:0]     squared_distance_o,
  output logic [RANK_W-1:0]     rank_o,
  output logic                  last_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers, kept raw; clamping is done on the read side
  // ---------------------------------------------------------------------------
  logic [PCNT_W-1:0] pcount_q;
  logic [DCNT_W-1:0] dcount_q;
  logic [KCNT_W-1:0] kcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= PCNT_RESET;
      dcount_q <= DCNT_RESET;
      kcount_q <= KCNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_POINT_COUNT:     pcount_q <= cfg_data_i[PCNT_W-1:0];
        CFG_DIMENSION_COUNT: dcount_q <= cfg_data_i[DCNT_W-1:0];
        CFG_NEIGHBOR_COUNT:  kcount_q <= cfg_data_i[KCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: last point index, last dimension, last rank
  logic [PCNT_W-1:0] n_eff;
  logic [DCNT_W-1:0] d_eff;
  logic [KCNT_W-1:0] k_sat;
  logic [PCNT_W-1:0] k_eff;
  logic [PIDX_W-1:0] n_m1;
  logic [DIM_W-1:0]  d_m1;
  logic [RANK_W-1:0] k_m1;
  logic [PCNT_W-1:0] n_less1;
  logic [PCNT_W-1:0] k_less1;
  logic [DCNT_W-1:0] d_less1;

  always_comb begin
    if (pcount_q < PCNT_W'(2))               n_eff = PCNT_W'(2);
    else if (pcount_q > PCNT_W'(MAX_POINTS)) n_eff = PCNT_W'(MAX_POINTS);
    else                                     n_eff = pcount_q;

    if (dcount_q < DCNT_W'(1))               d_eff = DCNT_W'(1);
    else if (dcount_q > DCNT_W'(MAX_DIMS))   d_eff = DCNT_W'(MAX_DIMS);
    else                                     d_eff = dcount_q;

    if (kcount_q < KCNT_W'(1))               k_sat = KCNT_W'(1);
    else if (kcount_q > KCNT_W'(MAX_K))      k_sat = KCNT_W'(MAX_K);
    else                                     k_sat = kcount_q;

    n_less1 = n_eff - PCNT_W'(1);
    // k never exceeds the number of other points
    if (PCNT_W'(k_sat) > n_less1) k_eff = n_less1;
    else                          k_eff = PCNT_W'(k_sat);

    k_less1 = k_eff - PCNT_W'(1);
    d_less1 = d_eff - DCNT_W'(1);
    n_m1    = n_less1[PIDX_W-1:0];
    k_m1    = k_less1[RANK_W-1:0];
    d_m1    = d_less1[DIM_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [PIDX_W-1:0] qidx_q, qidx_d;
  logic [PIDX_W-1:0] j_q, j_d;
  logic [DIM_W-1:0]  d_q, d_d;
  logic [RANK_W-1:0] rank_q, rank_d;

  logic accept;
  logic load_we;
  logic query_go;
  logic pipe_busy;

  pipe_tag_t issue_tag;
  logic [ADDR_W-1:0] store_raddr;
  logic              sel_rd;
  logic [PIDX_W-1:0] sel_raddr;
  logic              emit;

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign load_we  = accept && (operation_i == OP_LOAD);
  // queries outside the active points are dropped without results
  assign query_go = accept && (operation_i == OP_QUERY) &&
                    ({1'b0, point_index_i} < n_eff);

  logic last_j, last_d, last_rank;
  assign last_j    = (j_q == n_m1);
  assign last_d    = (d_q == d_m1);
  assign last_rank = (rank_q == k_m1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (query_go) state_d = ST_QLOAD;
      ST_QLOAD:    if (last_d) state_d = ST_DIST;
      ST_DIST:     if (last_d && last_j) state_d = ST_DRAIN;
      ST_DRAIN:    if (!pipe_busy) state_d = ST_SCAN;
      ST_SCAN:     if (last_j) state_d = ST_SCAN_END;
      ST_SCAN_END: state_d = ST_EMIT;
      ST_EMIT:     state_d = last_rank ? ST_IDLE : ST_SCAN;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs and counters
  always_comb begin
    qidx_d    = qidx_q;
    j_d       = j_q;
    d_d       = d_q;
    rank_d    = rank_q;
    issue_tag = '0;
    sel_rd    = 1'b0;
    sel_raddr = j_q;
    emit      = 1'b0;
    store_raddr = {qidx_q, d_q};
    case (state_q)
      ST_IDLE: begin
        if (query_go) begin
          qidx_d = point_index_i;
          j_d    = '0;
          d_d    = '0;
          rank_d = '0;
        end
      end
      ST_QLOAD: begin
        issue_tag.v     = 1'b1;
        issue_tag.qload = 1'b1;
        issue_tag.d     = d_q;
        store_raddr     = {qidx_q, d_q};
        d_d             = last_d ? '0 : d_q + DIM_W'(1);
      end
      ST_DIST: begin
        issue_tag.v     = 1'b1;
        issue_tag.j     = j_q;
        issue_tag.d     = d_q;
        issue_tag.first = (d_q == '0);
        issue_tag.last  = last_d;
        store_raddr     = {j_q, d_q};
        if (last_d) begin
          d_d = '0;
          j_d = last_j ? '0 : j_q + PIDX_W'(1);
        end else begin
          d_d = d_q + DIM_W'(1);
        end
      end
      ST_SCAN: begin
        sel_rd = 1'b1;
        j_d    = last_j ? '0 : j_q + PIDX_W'(1);
      end
      ST_EMIT: begin
        emit   = 1'b1;
        rank_d = rank_q + RANK_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      qidx_q  <= '0;
      j_q     <= '0;
      d_q     <= '0;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      qidx_q  <= qidx_d;
      j_q     <= j_d;
      d_q     <= d_d;
      rank_q  <= rank_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Point store: one write port for loads, one registered read port
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] store_mem [MAX_POINTS*MAX_DIMS];
  logic [COORD_BITS-1:0] store_rd_q;

  always_ff @(posedge clk_i) begin
    if (load_we) store_mem[{point_index_i, dim_index_i}] <= coord_value_i;
    store_rd_q <= store_mem[store_raddr];
  end

  // ---------------------------------------------------------------------------
  // Distance pipeline: read -> subtract/abs -> square -> accumulate
  // ---------------------------------------------------------------------------
  pipe_tag_t tag1_q, tag2_q, tag3_q;
  pipe_tag_t tag2_in;
  logic [COORD_BITS-1:0] qcoord_q [MAX_DIMS];
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]     diff_abs;
  logic [COORD_BITS-1:0] mag_q;
  logic [SQ_W-1:0]       sq_q;
  logic [DIST_W-1:0]     acc_q;
  logic [DIST_W-1:0]     acc_sum;

  assign pipe_busy = tag1_q.v || tag2_q.v || tag3_q.v;

  always_comb begin
    diff = DIFF_W'(signed'(store_rd_q)) - DIFF_W'(signed'(qcoord_q[tag1_q.d]));
    // magnitude never exceeds 2^COORD_BITS - 1
    diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    acc_sum  = (tag3_q.first ? '0 : acc_q) + DIST_W'(sq_q);
    // query-point fetches leave the pipeline after the first stage
    tag2_in   = tag1_q;
    tag2_in.v = tag1_q.v && !tag1_q.qload;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= issue_tag;
      tag2_q <= tag2_in;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag1_q.v && tag1_q.qload) qcoord_q[tag1_q.d] <= store_rd_q;
    mag_q <= diff_abs[COORD_BITS-1:0];
    sq_q  <= mag_q * mag_q;
    if (tag3_q.v) acc_q <= acc_sum;
  end

  // ---------------------------------------------------------------------------
  // Distance scratch: {used, distance} per point
  // ---------------------------------------------------------------------------
  logic [DIST_W:0]   dist_mem [MAX_POINTS];
  logic [DIST_W:0]   dist_rd_q;
  logic              dist_we;
  logic [PIDX_W-1:0] dist_waddr;
  logic [DIST_W:0]   dist_wdata;

  logic              cmp_v_q;
  logic [PIDX_W-1:0] cmp_j_q;
  logic              found_q, found_d;
  logic [PIDX_W-1:0] best_j_q;
  logic [DIST_W-1:0] best_d_q;
  logic              take;

  always_comb begin
    if (emit) begin
      // mark the chosen neighbor used for later passes
      dist_we    = 1'b1;
      dist_waddr = best_j_q;
      dist_wdata = {1'b1, best_d_q};
    end else begin
      dist_we    = tag3_q.v && tag3_q.last;
      dist_waddr = tag3_q.j;
      dist_wdata = {(tag3_q.j == qidx_q), acc_sum};
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    dist_rd_q <= dist_mem[sel_raddr];
  end

  // strict less-than over ascending index keeps ties on the lowest index
  assign take    = cmp_v_q && !dist_rd_q[DIST_W] &&
                   (!found_q || (dist_rd_q[DIST_W-1:0] < best_d_q));
  assign found_d = cmp_v_q && (found_q || take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_v_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      cmp_v_q <= sel_rd;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_j_q <= sel_raddr;
    if (take) begin
      best_j_q <= cmp_j_q;
      best_d_q <= dist_rd_q[DIST_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Result ports
  // ---------------------------------------------------------------------------
  assign result_valid_o     = emit;
  assign query_index_o      = qidx_q;
  assign neighbor_index_o   = best_j_q;
  assign squared_distance_o = best_d_q;
  assign rank_o             = rank_q;
  assign last_o             = last_rank;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_emit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> found_q)
    else $error("result without a selected neighbor");

  a_not_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (neighbor_index_o != query_index_o))
    else $error("query point reported as its own neighbor");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !busy_o)
    else $error("still busy after final result");

  a_acc_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag3_q.v && tag3_q.last) |-> (state_q == ST_DIST || state_q == ST_DRAIN))
    else $error("distance write outside distance phase");

  a_scan_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !pipe_busy)
    else $error("selection started before distances were written");

endmodule

[bench/brute_force_knn_search_tb.sv]
// Self-checking testbench for the brute-force k-nearest-neighbor search block.
`timescale 1ns / 1ps

module brute_force_knn_search_tb
  import bfknn_pkg::*;
();

  // Quiet cycles (no input transfer, no result) before the run is declared hung.
  // The longest silent stretch is the wait for the first result of a query.
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // Cycles to let pass after the last expected result before touching registers
  // or ending the run; a stray extra result still shows up in this window.
  localparam int unsigned SETTLE_CYCLES  = 16;

  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  // Coordinate value styles for the point loads
  localparam int MODE_FULL    = 0;  // any 16-bit value
  localparam int MODE_TIES    = 1;  // tiny range, lots of equal distances
  localparam int MODE_EXTREME = 2;  // rails, zero and -1

  typedef struct packed {
    logic [PIDX_W-1:0] query_index;
    logic [PIDX_W-1:0] neighbor_index;
    logic [DIST_W-1:0] squared_distance;
    logic [RANK_W-1:0] rank;
    logic              last;
  } knn_result_t;

  // Keeps a shadow of the point store and registers, works out the neighbor list
  // of every accepted query and checks the result stream against it.
  class knn_scoreboard;
    logic signed [COORD_BITS-1:0] coords [MAX_POINTS*MAX_DIMS];
    longint unsigned sq_sum [MAX_POINTS];
    bit taken [MAX_POINTS];
    logic [PCNT_W-1:0] pcnt;
    logic [DCNT_W-1:0] dcnt;
    logic [KCNT_W-1:0] kcnt;
    knn_result_t pending [$];
    int errors;

    function new();
      pcnt = PCNT_RESET;
      dcnt = DCNT_RESET;
      kcnt = KCNT_RESET;
      errors = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned active_points();
      return clamp(pcnt, 2, MAX_POINTS);
    endfunction

    function int unsigned active_dims();
      return clamp(dcnt, 1, MAX_DIMS);
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_POINT_COUNT:     pcnt = data[PCNT_W-1:0];
        CFG_DIMENSION_COUNT: dcnt = data[DCNT_W-1:0];
        CFG_NEIGHBOR_COUNT:  kcnt = data[KCNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Called on every accepted input transfer
    function void note_input(logic op, logic [PIDX_W-1:0] pidx, logic [DIM_W-1:0] didx,
                             logic signed [COORD_BITS-1:0] coord);
      int unsigned n, dims, k, q, best;
      longint diff;
      longint unsigned best_d;
      bit found;
      knn_result_t res;
      q = pidx;
      if (op == OP_LOAD) begin
        coords[q*MAX_DIMS + didx] = coord;
        return;
      end
      n = active_points();
      dims = active_dims();
      k = clamp(kcnt, 1, MAX_K);
      if (k > n - 1) k = n - 1;
      if (q >= n) return;  // query outside the active points: ignored
      for (int unsigned j = 0; j < n; j++) begin
        sq_sum[j] = 0;
        for (int unsigned d = 0; d < dims; d++) begin
          diff = longint'(coords[q*MAX_DIMS + d]) - longint'(coords[j*MAX_DIMS + d]);
          sq_sum[j] += longint'(diff * diff);
        end
        taken[j] = (j == q);
      end
      // k selection passes: strictly smaller wins, so ties keep the lowest index
      for (int unsigned pass_i = 0; pass_i < k; pass_i++) begin
        found = 0;
        best = 0;
        best_d = 0;
        for (int unsigned j = 0; j < n; j++) begin
          if (!taken[j] && (!found || sq_sum[j] < best_d)) begin
            found = 1;
            best = j;
            best_d = sq_sum[j];
          end
        end
        taken[best] = 1;
        res.query_index      = PIDX_W'(q);
        res.neighbor_index   = PIDX_W'(best);
        res.squared_distance = DIST_W'(best_d);
        res.rank             = RANK_W'(pass_i);
        res.last             = (pass_i + 1 == k);
        pending.push_back(res);
      end
    endfunction

    function void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Called on every result transfer
    function void check_result(knn_result_t act);
      knn_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none actual query %0d neighbor %0d",
                 $time, act.query_index, act.neighbor_index);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      check_field("query_index", exp_r.query_index, act.query_index);
      check_field("neighbor_index", exp_r.neighbor_index, act.neighbor_index);
      check_field("squared_distance", exp_r.squared_distance, act.squared_distance);
      check_field("rank", exp_r.rank, act.rank);
      check_field("last", exp_r.last, act.last);
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [CIDX_W-1:0]            cfg_index_i = '0;
  logic [CFG_W-1:0]             cfg_data_i = '0;
  logic                         start_i = 1'b0;
  logic                         busy_o;
  logic                         operation_i = OP_LOAD;
  logic [PIDX_W-1:0]            point_index_i = '0;
  logic [DIM_W-1:0]             dim_index_i = '0;
  logic signed [COORD_BITS-1:0] coord_value_i = '0;
  logic                         result_valid_o;
  logic [PIDX_W-1:0]            query_index_o;
  logic [PIDX_W-1:0]            neighbor_index_o;
  logic [DIST_W-1:0]            squared_distance_o;
  logic [RANK_W-1:0]            rank_o;
  logic                         last_o;

  knn_scoreboard sb;
  int            idle_pct;
  int unsigned   quiet_cycles;
  // Which coordinates have been written; a query never reads one that was not
  bit            loaded [MAX_POINTS][MAX_DIMS];

  brute_force_knn_search DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .operation_i       (operation_i),
    .point_index_i     (point_index_i),
    .dim_index_i       (dim_index_i),
    .coord_value_i     (coord_value_i),
    .result_valid_o    (result_valid_o),
    .query_index_o     (query_index_o),
    .neighbor_index_o  (neighbor_index_o),
    .squared_distance_o(squared_distance_o),
    .rank_o            (rank_o),
    .last_o            (last_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result monitor: the strobe lasts one cycle and cannot be held off, so every
  // edge with it high is a transfer. Values are sampled before the edge updates.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result('{query_index_o, neighbor_index_o, squared_distance_o, rank_o, last_o});
    end
  end

  // Watchdog: any input or result transfer restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("brute_force_knn_search_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [COORD_BITS-1:0] pick_coord(int mode);
    case (mode)
      MODE_TIES: return COORD_BITS'($urandom_range(4)) - COORD_BITS'(2);
      MODE_EXTREME: begin
        case ($urandom_range(3))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return COORD_BITS'($urandom());
    endcase
  endfunction

  // One input transfer. start stays high after acceptance so back-to-back items
  // need no second assignment in the same step; an idle gap lowers it first.
  task automatic send_item(input logic op, input int unsigned pidx, input int unsigned didx,
                           input logic signed [COORD_BITS-1:0] coord);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i       <= 1'b1;
    operation_i   <= op;
    point_index_i <= PIDX_W'(pidx);
    dim_index_i   <= DIM_W'(didx);
    coord_value_i <= coord;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_input(op, PIDX_W'(pidx), DIM_W'(didx), coord);
    if (op == OP_LOAD) loaded[pidx][didx] = 1'b1;
  endtask

  task automatic send_query(input int unsigned pidx);
    // dim and coord are don't-care on a query; randomize them anyway
    send_item(OP_QUERY, pidx, $urandom_range(MAX_DIMS-1), COORD_BITS'($urandom()));
  endtask

  // Drop start, wait for every expected result and SETTLE_CYCLES more, and for
  // busy low; registers may be written after this.
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Back-to-back writes of all three registers; we stays high across them
  task automatic write_regs(input int unsigned pc, input int unsigned dc, input int unsigned kc);
    logic [CIDX_W-1:0] idx [3];
    logic [CFG_W-1:0]  val [3];
    idx = '{CFG_POINT_COUNT, CFG_DIMENSION_COUNT, CFG_NEIGHBOR_COUNT};
    val = '{CFG_W'(pc), CFG_W'(dc), CFG_W'(kc)};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Load every coordinate the next queries read, refreshing some already there
  task automatic fill_points(input int unsigned n, input int unsigned dims, input int mode);
    for (int unsigned j = 0; j < n; j++) begin
      for (int unsigned d = 0; d < dims; d++) begin
        if (!loaded[j][d] || $urandom_range(3) == 0) send_item(OP_LOAD, j, d, pick_coord(mode));
      end
    end
  endtask

  // Reconfigure, fill, then a mix of queries, stray loads and ignored queries
  task automatic run_phase(input int unsigned pc, input int unsigned dc, input int unsigned kc,
                           input int nq, input int mode);
    int unsigned n;
    settle();
    write_regs(pc, dc, kc);
    n = sb.active_points();
    fill_points(n, sb.active_dims(), mode);
    repeat (nq) begin
      case ($urandom_range(9))
        0: send_item(OP_LOAD, $urandom_range(MAX_POINTS-1), $urandom_range(MAX_DIMS-1),
                     pick_coord(mode));
        1: send_query((n < MAX_POINTS) ? $urandom_range(MAX_POINTS-1, n) : $urandom_range(n-1));
        default: send_query($urandom_range(n-1));
      endcase
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 19;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // Reset registers: 2 points, 1 dim, k 5 clamped down to 1
    send_item(OP_LOAD, 0, 0, COORD_MIN);
    send_item(OP_LOAD, 1, 0, COORD_MAX);
    send_query(0);
    send_query(1);
    send_query(2);             // outside the active points, no result
    send_query(MAX_POINTS-1);  // same, at the top index

    // Saturating writes: point count 0 -> 2, k 0 -> 1, all 8 dims.
    // Opposite rails on every dim give the largest possible distance.
    settle();
    write_regs(0, MAX_DIMS, 0);
    for (int unsigned d = 1; d < MAX_DIMS; d++) begin
      send_item(OP_LOAD, 0, d, COORD_MIN);
      send_item(OP_LOAD, 1, d, COORD_MAX);
    end
    send_item(OP_LOAD, MAX_POINTS-1, MAX_DIMS-1, '1);
    send_query(0);

    // All distances equal: ties go to the lowest index; k 63 -> 32 -> 4
    settle();
    write_regs(5, 1, 63);
    for (int unsigned j = 0; j < 5; j++) send_item(OP_LOAD, j, 0, COORD_BITS'(7));
    send_query(2);

    // --- random part: small point sets, first phase with no idling ---
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 0 : 19;
      run_phase(($urandom_range(7) == 0) ? $urandom_range(1) : $urandom_range(5, 2),
                $urandom_range(4), $urandom_range(63), $urandom_range(6, 4),
                $urandom_range(MODE_EXTREME));
    end

    // --- 34 points, dims 0 -> 1, k 63 -> 32: every rank up to the last ---
    idle_pct = 19;
    settle();
    write_regs(34, 0, 63);
    fill_points(34, 1, MODE_FULL);
    send_query(33);
    send_query(0);
    run_phase(34, 1, MAX_K, 1, MODE_TIES);

    // Drain and finish
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("brute_force_knn_search_tb: done, clean");
    end else begin
      $display("brute_force_knn_search_tb: done, errors");
    end
    $finish;
  end

endmodule
